[rtl/core/hsvc_pkg.sv]
// Shared constants, types and helper functions for the HSV to RGB converter.
package hsvc_pkg;

    // Channel format: unsigned fixed point with CHAN_FRAC_BITS fraction bits in a 16-bit word.
    localparam int CHAN_FRAC_BITS = 15;
    localparam int CHAN_W         = 16;
    localparam int HUE_W          = 15;
    localparam int FRAC_W         = 16;

    // One sector of 60 degrees in 1/64 degree steps.
    localparam int SECTOR_UNITS = 3840;
    localparam int SECTORS      = 6;
    localparam int QUO_MAX      = ((1 << HUE_W) - 1) / SECTOR_UNITS;
    localparam int QUO_W        = $clog2(QUO_MAX + 1);
    localparam int REM_W        = $clog2(SECTOR_UNITS);

    // The fraction is (rem << FRAC_W) / SECTOR_UNITS. That dividend stays below
    // 2**DIV_SHIFT, so a floor reciprocal gives the quotient or one less.
    localparam int DIV_SHIFT = REM_W + FRAC_W;
    localparam int RECIP     = (1 << DIV_SHIFT) / SECTOR_UNITS;
    localparam int RECIP_W   = $clog2(RECIP + 1);
    localparam int PROD_W    = REM_W + RECIP_W;

    typedef logic [HUE_W-1:0]         hue_t;
    typedef logic [CHAN_W-1:0]        chan_t;
    typedef logic [FRAC_W-1:0]        frac_t;
    typedef logic [REM_W-1:0]         rem_t;
    typedef logic [QUO_W-1:0]         quo_t;
    typedef logic [2:0]               sector_t;
    typedef logic [RECIP_W-1:0]       recip_t;
    typedef logic [PROD_W-1:0]        prod_t;
    typedef logic [DIV_SHIFT-1:0]     wide_t;

    localparam chan_t ONE = chan_t'(1 << CHAN_FRAC_BITS);

    typedef enum logic [1:0] {
        CAND_V,
        CAND_P,
        CAND_Q,
        CAND_T
    } cand_t;

    typedef struct packed {
        cand_t red;
        cand_t green;
        cand_t blue;
    } pick_t;

    // Word handed from the hue splitter to the multiplier section.
    typedef struct packed {
        sector_t sector;
        frac_t   frac;
        chan_t   sat;
        chan_t   val;
        chan_t   alpha;
    } hue_word_t;

    // Word handed from the multiplier section to the channel select.
    typedef struct packed {
        sector_t sector;
        chan_t   v;
        chan_t   p;
        chan_t   q;
        chan_t   t;
        chan_t   alpha;
    } cand_word_t;

    function automatic chan_t sat_one(chan_t x);
        return (x > ONE) ? ONE : x;
    endfunction

    // Start of each sector in hue units.
    function automatic hue_t sector_base(quo_t q);
        return hue_t'(int'(q) * SECTOR_UNITS);
    endfunction

    // Standard HSV sector table.
    function automatic pick_t sector_pick(sector_t s);
        pick_t r;
        case (s)
            3'd0:    r = '{red: CAND_V, green: CAND_T, blue: CAND_P};
            3'd1:    r = '{red: CAND_Q, green: CAND_V, blue: CAND_P};
            3'd2:    r = '{red: CAND_P, green: CAND_V, blue: CAND_T};
            3'd3:    r = '{red: CAND_P, green: CAND_Q, blue: CAND_V};
            3'd4:    r = '{red: CAND_T, green: CAND_P, blue: CAND_V};
            3'd5:    r = '{red: CAND_V, green: CAND_P, blue: CAND_Q};
            default: r = '{red: CAND_V, green: CAND_V, blue: CAND_V};
        endcase
        return r;
    endfunction

    function automatic chan_t cand_mux(cand_t c, cand_word_t w);
        chan_t r;
        case (c)
            CAND_V:  r = w.v;
            CAND_P:  r = w.p;
            CAND_Q:  r = w.q;
            CAND_T:  r = w.t;
            default: r = w.v;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/hsvc_if.sv]
// Stream interfaces for the pixel input and the color output channels.
interface hsvc_in_if;
    logic                valid;
    logic                ready;
    hsvc_pkg::hue_t      hue_pos;
    hsvc_pkg::chan_t     sat_level;
    hsvc_pkg::chan_t     val_level;
    hsvc_pkg::chan_t     alpha_in;

    modport source (output valid, hue_pos, sat_level, val_level, alpha_in, input ready);
    modport sink   (input valid, hue_pos, sat_level, val_level, alpha_in, output ready);
endinterface

interface hsvc_out_if;
    logic                valid;
    logic                ready;
    hsvc_pkg::chan_t     red_out;
    hsvc_pkg::chan_t     green_out;
    hsvc_pkg::chan_t     blue_out;
    hsvc_pkg::chan_t     alpha_out;

    modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

[rtl/core/hsvc_hue_split.sv]
// Three-stage hue splitter: sector and remainder, reciprocal multiply, quotient correction.
module hsvc_hue_split (
    input  logic                  clk,
    input  logic                  rst_n,
    hsvc_in_if.sink               pix_in,
    output logic                  word_valid,
    input  logic                  word_ready,
    output hsvc_pkg::hue_word_t   word
);

    typedef struct packed {
        hsvc_pkg::sector_t sector;
        hsvc_pkg::rem_t    rem;
        hsvc_pkg::chan_t   sat;
        hsvc_pkg::chan_t   val;
        hsvc_pkg::chan_t   alpha;
    } s1_t;

    typedef struct packed {
        hsvc_pkg::sector_t sector;
        hsvc_pkg::rem_t    rem;
        hsvc_pkg::prod_t   prod;
        hsvc_pkg::chan_t   sat;
        hsvc_pkg::chan_t   val;
        hsvc_pkg::chan_t   alpha;
    } s2_t;

    logic                s1_valid_reg;
    logic                s2_valid_reg;
    logic                s3_valid_reg;
    s1_t                 s1_reg;
    s1_t                 s1_next;
    s2_t                 s2_reg;
    s2_t                 s2_next;
    hsvc_pkg::hue_word_t s3_reg;
    hsvc_pkg::hue_word_t s3_next;
    logic                s1_en;
    logic                s2_en;
    logic                s3_en;
    hsvc_pkg::quo_t      quo;
    hsvc_pkg::frac_t     q0;
    hsvc_pkg::wide_t     resid;

    // Each stage moves when it is empty or the stage after it moves.
    assign s3_en        = !s3_valid_reg || word_ready;
    assign s2_en        = !s2_valid_reg || s3_en;
    assign s1_en        = !s1_valid_reg || s2_en;
    assign pix_in.ready = s1_en;
    assign word_valid   = s3_valid_reg;
    assign word         = s3_reg;

    // Stage 1: whole sectors by parallel threshold compares.
    always_comb
    begin
        quo = '0;
        for (int m = 1; m <= hsvc_pkg::QUO_MAX; m++)
        begin
            if (pix_in.hue_pos >= hsvc_pkg::hue_t'(m * hsvc_pkg::SECTOR_UNITS))
            begin
                quo = hsvc_pkg::quo_t'(m);
            end
        end
        s1_next.rem    = hsvc_pkg::rem_t'(pix_in.hue_pos - hsvc_pkg::sector_base(quo));
        s1_next.sector = (quo >= hsvc_pkg::quo_t'(hsvc_pkg::SECTORS))
                       ? hsvc_pkg::sector_t'(quo - hsvc_pkg::quo_t'(hsvc_pkg::SECTORS))
                       : hsvc_pkg::sector_t'(quo);
        s1_next.sat    = hsvc_pkg::sat_one(pix_in.sat_level);
        s1_next.val    = hsvc_pkg::sat_one(pix_in.val_level);
        s1_next.alpha  = pix_in.alpha_in;
    end

    // Stage 2: remainder times the floor reciprocal of the sector size.
    always_comb
    begin
        s2_next.sector = s1_reg.sector;
        s2_next.rem    = s1_reg.rem;
        s2_next.prod   = hsvc_pkg::prod_t'(s1_reg.rem)
                       * hsvc_pkg::prod_t'(hsvc_pkg::RECIP);
        s2_next.sat    = s1_reg.sat;
        s2_next.val    = s1_reg.val;
        s2_next.alpha  = s1_reg.alpha;
    end

    // Stage 3: the estimate is exact or one short; the residue tells which.
    always_comb
    begin
        q0    = s2_reg.prod[hsvc_pkg::REM_W +: hsvc_pkg::FRAC_W];
        resid = {s2_reg.rem, {hsvc_pkg::FRAC_W{1'b0}}}
              - hsvc_pkg::wide_t'(q0) * hsvc_pkg::wide_t'(hsvc_pkg::SECTOR_UNITS);
        s3_next.sector = s2_reg.sector;
        s3_next.frac   = (resid >= hsvc_pkg::wide_t'(hsvc_pkg::SECTOR_UNITS))
                       ? q0 + hsvc_pkg::frac_t'(1) : q0;
        s3_next.sat    = s2_reg.sat;
        s3_next.val    = s2_reg.val;
        s3_next.alpha  = s2_reg.alpha;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_valid_reg <= pix_in.valid;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_en)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && pix_in.valid)
        begin
            s1_reg <= s1_next;
        end
        if (s2_en && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
        if (s3_en && s2_valid_reg)
        begin
            s3_reg <= s3_next;
        end
    end

endmodule

[rtl/core/hsvc_chan_mult.sv]
// Two-stage multiplier section that forms the v, p, q and t candidates.
module hsvc_chan_mult (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  hsvc_pkg::hue_word_t    in_word,
    output logic                   word_valid,
    input  logic                   word_ready,
    output hsvc_pkg::cand_word_t   word
);

    typedef struct packed {
        hsvc_pkg::sector_t sector;
        hsvc_pkg::chan_t   fs;
        hsvc_pkg::chan_t   gs;
        hsvc_pkg::chan_t   sat;
        hsvc_pkg::chan_t   val;
        hsvc_pkg::chan_t   alpha;
    } s4_t;

    localparam int FS_W = hsvc_pkg::FRAC_W + hsvc_pkg::CHAN_W;
    localparam int GS_W = hsvc_pkg::FRAC_W + 1 + hsvc_pkg::CHAN_W;
    localparam int CP_W = 2 * hsvc_pkg::CHAN_W;

    logic                 s4_valid_reg;
    logic                 s5_valid_reg;
    s4_t                  s4_reg;
    s4_t                  s4_next;
    hsvc_pkg::cand_word_t s5_reg;
    hsvc_pkg::cand_word_t s5_next;
    logic                 s4_en;
    logic                 s5_en;
    logic [FS_W-1:0]      fs_prod;
    logic [GS_W-1:0]      gs_prod;
    logic [hsvc_pkg::FRAC_W:0] frac_comp;
    logic [CP_W-1:0]      p_prod;
    logic [CP_W-1:0]      q_prod;
    logic [CP_W-1:0]      t_prod;

    assign s5_en      = !s5_valid_reg || word_ready;
    assign s4_en      = !s4_valid_reg || s5_en;
    assign in_ready   = s4_en;
    assign word_valid = s5_valid_reg;
    assign word       = s5_reg;

    // Stage 4: f*s and (1-f)*s, both in channel units.
    always_comb
    begin
        frac_comp = (hsvc_pkg::FRAC_W + 1)'(1 << hsvc_pkg::FRAC_W)
                  - (hsvc_pkg::FRAC_W + 1)'(in_word.frac);
        fs_prod   = FS_W'(in_word.frac) * FS_W'(in_word.sat);
        gs_prod   = GS_W'(frac_comp) * GS_W'(in_word.sat);
        s4_next.sector = in_word.sector;
        s4_next.fs     = fs_prod[hsvc_pkg::FRAC_W +: hsvc_pkg::CHAN_W];
        s4_next.gs     = gs_prod[hsvc_pkg::FRAC_W +: hsvc_pkg::CHAN_W];
        s4_next.sat    = in_word.sat;
        s4_next.val    = in_word.val;
        s4_next.alpha  = in_word.alpha;
    end

    // Stage 5: scale v by one minus each term. Clamped inputs keep every difference nonnegative.
    always_comb
    begin
        p_prod = CP_W'(s4_reg.val) * CP_W'(hsvc_pkg::ONE - s4_reg.sat);
        q_prod = CP_W'(s4_reg.val) * CP_W'(hsvc_pkg::ONE - s4_reg.fs);
        t_prod = CP_W'(s4_reg.val) * CP_W'(hsvc_pkg::ONE - s4_reg.gs);
        s5_next.sector = s4_reg.sector;
        s5_next.v      = s4_reg.val;
        s5_next.p      = p_prod[hsvc_pkg::CHAN_FRAC_BITS +: hsvc_pkg::CHAN_W];
        s5_next.q      = q_prod[hsvc_pkg::CHAN_FRAC_BITS +: hsvc_pkg::CHAN_W];
        s5_next.t      = t_prod[hsvc_pkg::CHAN_FRAC_BITS +: hsvc_pkg::CHAN_W];
        s5_next.alpha  = s4_reg.alpha;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (s4_en)
            begin
                s4_valid_reg <= in_valid;
            end
            if (s5_en)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_en && in_valid)
        begin
            s4_reg <= s4_next;
        end
        if (s5_en && s4_valid_reg)
        begin
            s5_reg <= s5_next;
        end
    end

endmodule

[rtl/core/hsv_to_rgb_converter.sv]
// HSV to RGB converter: six-stage pipeline, takes one pixel per clock when the sink is ready.
//
// Each input word carries one pixel: hue in 1/64 degree steps and saturation, value and alpha
// as unsigned Q1.15. The output word carries red, green and blue in Q1.15, with alpha copied
// through. The block accepts a word every cycle and puts out a word every cycle when the sink is
// ready. Each pixel passes through six register stages in order from input to output: sector
// compare, reciprocal multiply, fraction correction, saturation products, channel products,
// and sector select into the output register. Words come out in input order. A stall at the
// output fills empty stages first, so input ready drops only when all six stages hold a pixel.
// Saturation and value above 1.0 are clamped to 1.0, and a hue at or past 360 degrees wraps.
module hsv_to_rgb_converter (
    input  logic        clk,
    input  logic        rst_n,
    hsvc_in_if.sink     pix_in,
    hsvc_out_if.source  pix_out
);

    logic                 hue_valid;
    logic                 hue_ready;
    hsvc_pkg::hue_word_t  hue_word;
    logic                 cand_valid;
    logic                 cand_ready;
    hsvc_pkg::cand_word_t cand_word;
    hsvc_pkg::pick_t      pick;
    logic                 out_valid_reg;
    hsvc_pkg::chan_t      red_reg;
    hsvc_pkg::chan_t      green_reg;
    hsvc_pkg::chan_t      blue_reg;
    hsvc_pkg::chan_t      alpha_reg;
    hsvc_pkg::chan_t      red_next;
    hsvc_pkg::chan_t      green_next;
    hsvc_pkg::chan_t      blue_next;
    logic                 out_en;

    hsvc_hue_split u_hue_split (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_in     (pix_in),
        .word_valid (hue_valid),
        .word_ready (hue_ready),
        .word       (hue_word)
    );

    hsvc_chan_mult u_chan_mult (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (hue_valid),
        .in_ready   (hue_ready),
        .in_word    (hue_word),
        .word_valid (cand_valid),
        .word_ready (cand_ready),
        .word       (cand_word)
    );

    // Stage 6: pick the channels through the sector table.
    always_comb
    begin
        pick       = hsvc_pkg::sector_pick(cand_word.sector);
        red_next   = hsvc_pkg::cand_mux(pick.red, cand_word);
        green_next = hsvc_pkg::cand_mux(pick.green, cand_word);
        blue_next  = hsvc_pkg::cand_mux(pick.blue, cand_word);
    end

    assign out_en            = !out_valid_reg || pix_out.ready;
    assign cand_ready        = out_en;
    assign pix_out.valid     = out_valid_reg;
    assign pix_out.red_out   = red_reg;
    assign pix_out.green_out = green_reg;
    assign pix_out.blue_out  = blue_reg;
    assign pix_out.alpha_out = alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= cand_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en && cand_valid)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            alpha_reg <= cand_word.alpha;
        end
    end

`ifndef ASSERT_OFF
    // The sector is reduced to the six-row table before it leaves the hue splitter.
    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        hue_valid |-> (hue_word.sector < hsvc_pkg::sector_t'(hsvc_pkg::SECTORS)))
        else $error("sector out of range after hue split");

    // With clamped inputs no scaled candidate can exceed the value term.
    a_cand_order: assert property (@(posedge clk) disable iff (!rst_n)
        cand_valid |-> (cand_word.p <= cand_word.v && cand_word.q <= cand_word.v
                        && cand_word.t <= cand_word.v))
        else $error("candidate exceeds value term");

    // Every color channel stays within 1.0.
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (red_reg <= hsvc_pkg::ONE && green_reg <= hsvc_pkg::ONE
                           && blue_reg <= hsvc_pkg::ONE))
        else $error("color channel above 1.0");
`endif

endmodule
